### src/bmf_pkg.sv
// Shared types and constants of the 3x3 box mean filter.
// No dependencies; used by every module in src.
package bmf_pkg;

	// Default largest image side and the image size after reset
	localparam int MAX_SIDE_DEF = 512;
	localparam int SIZE_RESET   = 512;

	// Field widths
	localparam int PIX_W   = 16;   // one color channel
	localparam int CFG_W   = 10;   // image size register
	localparam int COORD_W = 9;    // row/column on the result side
	localparam int VSUM_W  = 18;   // sum of up to 3 pixels in one column
	localparam int SUM_W   = 20;   // sum of up to 9 pixels

	// Division by the window count: q = (sum * recip) >> RECIP_SHIFT
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 24;
	localparam int PROD_W      = SUM_W + RECIP_W;

	// Result slots of one request, in emission order
	localparam logic [1:0] SLOT_UP_LEFT  = 2'd0;   // row R-1, column C-1
	localparam logic [1:0] SLOT_UP_HERE  = 2'd1;   // row R-1, column C
	localparam logic [1:0] SLOT_CUR_LEFT = 2'd2;   // row R,   column C-1
	localparam logic [1:0] SLOT_CUR_HERE = 2'd3;   // row R,   column C
	localparam int         NUM_SLOTS     = 4;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	typedef struct packed {
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
	} sum3_t;

	// One pending window: its sum and its clipped extent
	typedef struct packed {
		sum3_t      sum;
		logic [1:0] nrows;
		logic [1:0] ncols;
	} slot_t;

	// All windows closed by one request
	typedef struct packed {
		logic [NUM_SLOTS-1:0]        mask;
		logic [COORD_W-1:0]          row;   // row of the request
		logic [COORD_W-1:0]          col;   // column of the request
		slot_t [NUM_SLOTS-1:0]       slot;
	} job_t;

	// Reciprocal of the in-bounds count (1, 2, 3, 4, 6 or 9), exact for sums below 2^21
	function automatic logic [RECIP_W-1:0] recip(input logic [1:0] nrows,
			input logic [1:0] ncols);
		logic [3:0] key;
		key = {nrows, ncols};
		case (key)
			{2'd1, 2'd2}, {2'd2, 2'd1}: return RECIP_W'(25'd8388608);
			{2'd1, 2'd3}, {2'd3, 2'd1}: return RECIP_W'(25'd5592406);
			{2'd2, 2'd2}:               return RECIP_W'(25'd4194304);
			{2'd2, 2'd3}, {2'd3, 2'd2}: return RECIP_W'(25'd2796203);
			{2'd3, 2'd3}:               return RECIP_W'(25'd1864136);
			default:                    return RECIP_W'(25'd16777216);
		endcase
	endfunction

endpackage

### src/bmf_line_mem.sv
// Line store: three image rows of packed pixels, one write and two read ports.
// Read data is registered and held while no read is issued. Uses bmf_pkg.
module bmf_line_mem #(
	parameter int DEPTH = 3 * bmf_pkg::MAX_SIDE_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  bmf_pkg::pix_t  wdata,
	input  logic           re,
	input  logic [AW-1:0]  raddr_a,
	input  logic [AW-1:0]  raddr_b,
	output bmf_pkg::pix_t  rdata_a,
	output bmf_pkg::pix_t  rdata_b
);

	bmf_pkg::pix_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### src/bmf_window.sv
// Front end: raster position, line store addressing, column sums and the
// up to four window sums closed by each pixel. Uses bmf_pkg; drives bmf_line_mem.
module bmf_window #(
	parameter int MAX_SIDE = bmf_pkg::MAX_SIDE_DEF,
	localparam int PW = $clog2(MAX_SIDE),
	localparam int SW = $clog2(MAX_SIDE + 1),
	localparam int AW = $clog2(3 * MAX_SIDE)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [SW-1:0]  side,
	input  logic           restart,
	input  logic           in_valid,
	output logic           in_ready,
	input  bmf_pkg::pix_t  in_pix,
	output logic           mem_we,
	output logic [AW-1:0]  mem_waddr,
	output bmf_pkg::pix_t  mem_wdata,
	output logic           mem_re,
	output logic [AW-1:0]  mem_raddr_a,
	output logic [AW-1:0]  mem_raddr_b,
	input  bmf_pkg::pix_t  mem_rdata_a,
	input  bmf_pkg::pix_t  mem_rdata_b,
	output bmf_pkg::job_t  job,
	output logic           job_valid,
	input  logic           job_ready
);

	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic r_last;
		logic c_ge1;
		logic c_ge2;
		logic c_last;
		logic [bmf_pkg::COORD_W-1:0] row;
		logic [bmf_pkg::COORD_W-1:0] col;
	} pos_t;

	typedef struct packed {
		logic [bmf_pkg::VSUM_W-1:0] blue;
		logic [bmf_pkg::VSUM_W-1:0] green;
		logic [bmf_pkg::VSUM_W-1:0] red;
	} col3_t;

	function automatic logic [AW-1:0] bank_base(input logic [1:0] bank);
		case (bank)
			2'd1:    return AW'(MAX_SIDE);
			2'd2:    return AW'(2 * MAX_SIDE);
			default: return '0;
		endcase
	endfunction

	function automatic col3_t vsum3(input bmf_pkg::pix_t a, input bmf_pkg::pix_t b,
			input bmf_pkg::pix_t c);
		col3_t s;
		s.red   = bmf_pkg::VSUM_W'(a.red)   + bmf_pkg::VSUM_W'(b.red)
			+ bmf_pkg::VSUM_W'(c.red);
		s.green = bmf_pkg::VSUM_W'(a.green) + bmf_pkg::VSUM_W'(b.green)
			+ bmf_pkg::VSUM_W'(c.green);
		s.blue  = bmf_pkg::VSUM_W'(a.blue)  + bmf_pkg::VSUM_W'(b.blue)
			+ bmf_pkg::VSUM_W'(c.blue);
		return s;
	endfunction

	function automatic bmf_pkg::sum3_t hsum3(input col3_t a, input col3_t b, input col3_t c);
		bmf_pkg::sum3_t s;
		s.red   = bmf_pkg::SUM_W'(a.red)   + bmf_pkg::SUM_W'(b.red)
			+ bmf_pkg::SUM_W'(c.red);
		s.green = bmf_pkg::SUM_W'(a.green) + bmf_pkg::SUM_W'(b.green)
			+ bmf_pkg::SUM_W'(c.green);
		s.blue  = bmf_pkg::SUM_W'(a.blue)  + bmf_pkg::SUM_W'(b.blue)
			+ bmf_pkg::SUM_W'(c.blue);
		return s;
	endfunction

	logic [PW-1:0]  row_q, col_q;
	logic [1:0]     bank_q, bank_up, bank_m1, bank_m2;
	logic [SW-1:0]  side_m1;
	logic           row_last, col_last, accept, adv_s1;
	logic           valid_s1;
	pos_t           pos_s1;
	bmf_pkg::pix_t  pix_s1;
	col3_t          ca1_q, ca2_q, cb1_q, cb2_q;   // columns C-1 and C-2, rows R-1 / R
	col3_t          va, vb;
	logic [1:0]     nr_up, nr_cur, nc_left, nc_here;

	// position compares and bank arithmetic (bank = row mod 3)
	always_comb begin
		side_m1  = side - SW'(1);
		row_last = (SW'(row_q) == side_m1);
		col_last = (SW'(col_q) == side_m1);
		bank_up  = (bank_q == 2'd2) ? 2'd0 : bank_q + 2'd1;
		bank_m1  = (bank_q == 2'd0) ? 2'd2 : bank_q - 2'd1;
		case (bank_q)
			2'd0:    bank_m2 = 2'd1;
			2'd1:    bank_m2 = 2'd2;
			default: bank_m2 = 2'd0;
		endcase
	end

	// handshake: s1 drains when its windows are handed on or it closes none
	assign adv_s1   = valid_s1 && (!(|job.mask) || job_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// line store: write this pixel, fetch the two rows above at this column
	assign mem_we      = accept;
	assign mem_waddr   = bank_base(bank_q) + AW'(col_q);
	assign mem_wdata   = in_pix;
	assign mem_re      = accept;
	assign mem_raddr_a = bank_base(bank_m1) + AW'(col_q);
	assign mem_raddr_b = bank_base(bank_m2) + AW'(col_q);

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			bank_q <= 2'd0;
		end else if (restart) begin
			row_q  <= '0;
			col_q  <= '0;
			bank_q <= 2'd0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					bank_q <= 2'd0;
				end else begin
					row_q  <= row_q + PW'(1);
					bank_q <= bank_up;
				end
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1        <= in_pix;
			pos_s1.r_ge1  <= (row_q != '0);
			pos_s1.r_ge2  <= (row_q > PW'(1));
			pos_s1.r_last <= row_last;
			pos_s1.c_ge1  <= (col_q != '0);
			pos_s1.c_ge2  <= (col_q > PW'(1));
			pos_s1.c_last <= col_last;
			pos_s1.row    <= bmf_pkg::COORD_W'(row_q);
			pos_s1.col    <= bmf_pkg::COORD_W'(col_q);
		end
	end

	// vertical sums of this column for row R-1 and for row R
	always_comb begin
		va = vsum3(mem_rdata_a, pix_s1, pos_s1.r_ge2 ? mem_rdata_b : '0);
		vb = vsum3(pix_s1, pos_s1.r_ge1 ? mem_rdata_a : '0, '0);
	end

	// column sum shift line
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ca2_q <= ca1_q;
			ca1_q <= va;
			cb2_q <= cb1_q;
			cb1_q <= vb;
		end
	end

	// windows closed by this pixel
	always_comb begin
		nr_up   = pos_s1.r_ge2 ? 2'd3 : 2'd2;
		nr_cur  = pos_s1.r_ge1 ? 2'd2 : 2'd1;
		nc_left = pos_s1.c_ge2 ? 2'd3 : 2'd2;
		nc_here = pos_s1.c_ge1 ? 2'd2 : 2'd1;

		job.row = pos_s1.row;
		job.col = pos_s1.col;
		job.mask[bmf_pkg::SLOT_UP_LEFT]  = pos_s1.r_ge1  && pos_s1.c_ge1;
		job.mask[bmf_pkg::SLOT_UP_HERE]  = pos_s1.r_ge1  && pos_s1.c_last;
		job.mask[bmf_pkg::SLOT_CUR_LEFT] = pos_s1.r_last && pos_s1.c_ge1;
		job.mask[bmf_pkg::SLOT_CUR_HERE] = pos_s1.r_last && pos_s1.c_last;

		job.slot[bmf_pkg::SLOT_UP_LEFT].sum   =
			hsum3(pos_s1.c_ge2 ? ca2_q : '0, ca1_q, va);
		job.slot[bmf_pkg::SLOT_UP_LEFT].nrows = nr_up;
		job.slot[bmf_pkg::SLOT_UP_LEFT].ncols = nc_left;

		job.slot[bmf_pkg::SLOT_UP_HERE].sum   =
			hsum3(pos_s1.c_ge1 ? ca1_q : '0, va, '0);
		job.slot[bmf_pkg::SLOT_UP_HERE].nrows = nr_up;
		job.slot[bmf_pkg::SLOT_UP_HERE].ncols = nc_here;

		job.slot[bmf_pkg::SLOT_CUR_LEFT].sum   =
			hsum3(pos_s1.c_ge2 ? cb2_q : '0, cb1_q, vb);
		job.slot[bmf_pkg::SLOT_CUR_LEFT].nrows = nr_cur;
		job.slot[bmf_pkg::SLOT_CUR_LEFT].ncols = nc_left;

		job.slot[bmf_pkg::SLOT_CUR_HERE].sum   =
			hsum3(pos_s1.c_ge1 ? cb1_q : '0, vb, '0);
		job.slot[bmf_pkg::SLOT_CUR_HERE].nrows = nr_cur;
		job.slot[bmf_pkg::SLOT_CUR_HERE].ncols = nc_here;
	end

	assign job_valid = valid_s1 && (|job.mask);

endmodule

### src/bmf_mean.sv
// Back end: sends the windows of one request one per cycle, while the output does
// not stall, through the reciprocal divider and the output register. Uses bmf_pkg.
module bmf_mean (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bmf_pkg::job_t                 job,
	input  logic                          job_valid,
	output logic                          job_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bmf_pkg::COORD_W-1:0]   out_row,
	output logic [bmf_pkg::COORD_W-1:0]   out_col,
	output logic [bmf_pkg::PIX_W-1:0]     out_red,
	output logic [bmf_pkg::PIX_W-1:0]     out_green,
	output logic [bmf_pkg::PIX_W-1:0]     out_blue,
	output logic                          run_last,
	output logic                          frame_done
);

	localparam int SH = bmf_pkg::RECIP_SHIFT;
	localparam int PX = bmf_pkg::PIX_W;

	bmf_pkg::job_t                   job_s2;
	logic [bmf_pkg::NUM_SLOTS-1:0]   pend_s2, pick, remain;
	logic                            valid_s2, load, issue, last;
	logic [1:0]                      sel;
	bmf_pkg::slot_t                  cur;
	logic [bmf_pkg::RECIP_W-1:0]     rcp;

	logic                            valid_s3, run_last_s3, frame_done_s3;
	logic [bmf_pkg::COORD_W-1:0]     row_s3, col_s3;
	logic [bmf_pkg::PROD_W-1:0]      red_s3, green_s3, blue_s3;
	logic                            out_free, s3_free, s3_adv;

	// lowest pending slot goes first
	always_comb begin
		sel = bmf_pkg::SLOT_CUR_HERE;
		for (int i = bmf_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (pend_s2[i]) begin
				sel = 2'(i);
			end
		end
		pick   = bmf_pkg::NUM_SLOTS'(1) << sel;
		remain = pend_s2 & ~pick;
		last   = (remain == '0);
		cur    = job_s2.slot[sel];
		rcp    = bmf_pkg::recip(cur.nrows, cur.ncols);
	end

	// stage handshakes
	assign out_free  = !out_valid || out_ready;
	assign s3_adv    = valid_s3 && out_free;
	assign s3_free   = !valid_s3 || out_free;
	assign issue     = valid_s2 && s3_free;
	assign job_ready = !valid_s2 || (issue && last);
	assign load      = job_valid && job_ready;

	// stage 2: request holding register and pending slot mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pend_s2  <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			pend_s2  <= job.mask;
		end else if (issue) begin
			pend_s2 <= remain;
			if (last) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s2 <= job;
		end
	end

	// stage 3: multiply by the reciprocal of the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			red_s3        <= bmf_pkg::PROD_W'(cur.sum.red)   * bmf_pkg::PROD_W'(rcp);
			green_s3      <= bmf_pkg::PROD_W'(cur.sum.green) * bmf_pkg::PROD_W'(rcp);
			blue_s3       <= bmf_pkg::PROD_W'(cur.sum.blue)  * bmf_pkg::PROD_W'(rcp);
			row_s3        <= sel[1] ? job_s2.row : job_s2.row - bmf_pkg::COORD_W'(1);
			col_s3        <= sel[0] ? job_s2.col : job_s2.col - bmf_pkg::COORD_W'(1);
			run_last_s3   <= last;
			frame_done_s3 <= (sel == bmf_pkg::SLOT_CUR_HERE);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_adv) begin
			out_row    <= row_s3;
			out_col    <= col_s3;
			out_red    <= red_s3[SH +: PX];
			out_green  <= green_s3[SH +: PX];
			out_blue   <= blue_s3[SH +: PX];
			run_last   <= run_last_s3;
			frame_done <= frame_done_s3;
		end
	end

endmodule

### src/box_mean_filter_3x3_top.sv
// 3x3 box mean filter, top level: image size register, line store, front and back end.
// Depends on bmf_pkg, bmf_line_mem, bmf_window and bmf_mean.
//
// Pixels enter in raster order, one request per clock while the output is not
// stalled. A pixel that closes no window or one window is then taken every cycle;
// a pixel that closes more (up to four, at the last row and column) holds in_ready
// low while its windows issue, since all results leave through one divider lane at
// one per clock. A result passes the stage 1, 2 and 3 registers and the output
// register after its pixel. The line store is a 3*MAX_SIDE x 48-bit memory with
// one write and two registered read ports; each entry is used only after the
// current frame wrote it, so it needs no clearing after reset. Writing image_size
// (through cfg_we/cfg_wdata, while the filter is idle) restarts the frame at row
// 0, column 0; 0 counts as 1 and values above MAX_SIDE saturate.
module box_mean_filter_3x3_top #(
	parameter int MAX_SIDE = bmf_pkg::MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bmf_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bmf_pkg::PIX_W-1:0]     in_red,
	input  logic [bmf_pkg::PIX_W-1:0]     in_green,
	input  logic [bmf_pkg::PIX_W-1:0]     in_blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bmf_pkg::COORD_W-1:0]   out_row,
	output logic [bmf_pkg::COORD_W-1:0]   out_col,
	output logic [bmf_pkg::PIX_W-1:0]     out_red,
	output logic [bmf_pkg::PIX_W-1:0]     out_green,
	output logic [bmf_pkg::PIX_W-1:0]     out_blue,
	output logic                          run_last,
	output logic                          frame_done
);

	localparam int SW       = $clog2(MAX_SIDE + 1);
	localparam int EW       = (SW > bmf_pkg::CFG_W) ? SW : bmf_pkg::CFG_W;
	localparam int AW       = $clog2(3 * MAX_SIDE);
	localparam int SIZE_RST = (bmf_pkg::SIZE_RESET > MAX_SIDE) ? MAX_SIDE
		: bmf_pkg::SIZE_RESET;

	logic [SW-1:0]   size_q, size_d;
	logic [EW-1:0]   wr_val;
	bmf_pkg::pix_t   in_pix;
	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr_a, mem_raddr_b;
	bmf_pkg::pix_t   mem_wdata, mem_rdata_a, mem_rdata_b;
	bmf_pkg::job_t   job;
	logic            job_valid, job_ready;

	// clamp the written size to 1..MAX_SIDE
	always_comb begin
		wr_val = EW'(cfg_wdata);
		if (wr_val == '0) begin
			size_d = SW'(1);
		end else if (wr_val > EW'(MAX_SIDE)) begin
			size_d = SW'(MAX_SIDE);
		end else begin
			size_d = SW'(wr_val);
		end
	end

	// image size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(SIZE_RST);
		end else if (cfg_we) begin
			size_q <= size_d;
		end
	end

	assign in_pix.red   = in_red;
	assign in_pix.green = in_green;
	assign in_pix.blue  = in_blue;

	bmf_line_mem #(
		.DEPTH (3 * MAX_SIDE)
	) u_line_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	bmf_window #(
		.MAX_SIDE (MAX_SIDE)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.side        (size_q),
		.restart     (cfg_we),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_pix      (in_pix),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b),
		.job         (job),
		.job_valid   (job_valid),
		.job_ready   (job_ready)
	);

	bmf_mean u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

endmodule

### test/tb_top.sv
// Self-checking testbench for box_mean_filter_3x3_top: pixel frames of many sizes go in,
// and each smoothed pixel is checked against a clipped 3x3 window mean predicted here.
// Depends on bmf_pkg and the box_mean_filter_3x3_top RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE_MAX       = bmf_pkg::MAX_SIDE_DEF;
	localparam int SIZE_RESET     = bmf_pkg::SIZE_RESET;
	localparam int COORD_W        = bmf_pkg::COORD_W;
	localparam int PIX_W          = bmf_pkg::PIX_W;
	localparam int CFG_W          = bmf_pkg::CFG_W;
	localparam int SETTLE         = 8;     // settling margin for the pipeline
	localparam int WATCHDOG_LIMIT = 400;
	localparam int RANDOM_ITEMS   = 90;

	typedef bmf_pkg::pix_t pix_t;

	// One smoothed output pixel, as seen on the result ports
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   red;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   blue;
		logic               run_last;
		logic               frame_done;
	} smooth_pix_t;

	// Predicts the smoothed pixels and checks what the filter returns
	class box_mean_board;
		pix_t          line_pix [3*SIDE_MAX];
		int unsigned   side;
		int unsigned   row;
		int unsigned   col;
		smooth_pix_t   expected_means[$];
		int            errors;

		function new();
			side   = SIZE_RESET;
			row    = 0;
			col    = 0;
			errors = 0;
		endfunction

		function int unsigned slot(int unsigned r, int unsigned c);
			return (r % 3) * SIDE_MAX + c;
		endfunction

		// Image size write: zero counts as one, large values saturate, frame restarts
		function void set_size(logic [CFG_W-1:0] v);
			side = (v == '0) ? 1 : int'(v);
			if (side > SIDE_MAX)
				side = SIDE_MAX;
			row = 0;
			col = 0;
		endfunction

		// Mean over the window around (r, c), clipped at the image borders
		function smooth_pix_t window_mean(int unsigned r, int unsigned c);
			smooth_pix_t m;
			pix_t        p;
			int unsigned r_lo, r_hi, c_lo, c_hi, cnt, sum_r, sum_g, sum_b;
			r_lo  = (r > 0) ? r - 1 : 0;
			r_hi  = (r + 1 < side) ? r + 1 : side - 1;
			c_lo  = (c > 0) ? c - 1 : 0;
			c_hi  = (c + 1 < side) ? c + 1 : side - 1;
			cnt   = 0;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			for (int unsigned rr = r_lo; rr <= r_hi; rr++) begin
				for (int unsigned cc = c_lo; cc <= c_hi; cc++) begin
					p      = line_pix[slot(rr, cc)];
					sum_r += p.red;
					sum_g += p.green;
					sum_b += p.blue;
					cnt++;
				end
			end
			m.row        = COORD_W'(r);
			m.col        = COORD_W'(c);
			m.red        = PIX_W'(sum_r / cnt);
			m.green      = PIX_W'(sum_g / cnt);
			m.blue       = PIX_W'(sum_b / cnt);
			m.run_last   = 1'b0;
			m.frame_done = (r == side - 1) && (c == side - 1);
			return m;
		endfunction

		// Accepted pixel: store it and queue every window it completes
		function void note_pixel(pix_t px);
			int unsigned rows[$];
			int unsigned cols[$];
			smooth_pix_t m;
			line_pix[slot(row, col)] = px;
			if (row >= 1)
				rows.push_back(row - 1);
			if (row == side - 1)
				rows.push_back(row);
			if (col >= 1)
				cols.push_back(col - 1);
			if (col == side - 1)
				cols.push_back(col);
			for (int i = 0; i < rows.size(); i++) begin
				for (int j = 0; j < cols.size(); j++) begin
					m = window_mean(rows[i], cols[j]);
					m.run_last = (i == rows.size() - 1) && (j == cols.size() - 1);
					expected_means.push_back(m);
				end
			end
			col++;
			if (col >= side) begin
				col = 0;
				row++;
				if (row >= side)
					row = 0;
			end
		endfunction

		function int pending();
			return expected_means.size();
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Accepted result: compare with the oldest pending window
		function void check_result(smooth_pix_t got);
			smooth_pix_t want;
			if (expected_means.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual row %0d col %0d",
					$time, got.row, got.col);
				errors++;
				return;
			end
			want = expected_means.pop_front();
			check_field("out_row", want.row, got.row);
			check_field("out_col", want.col, got.col);
			check_field("out_red", want.red, got.red);
			check_field("out_green", want.green, got.green);
			check_field("out_blue", want.blue, got.blue);
			check_field("run_last", want.run_last, got.run_last);
			check_field("frame_done", want.frame_done, got.frame_done);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [PIX_W-1:0]   in_red;
	logic [PIX_W-1:0]   in_green;
	logic [PIX_W-1:0]   in_blue;
	logic               out_valid;
	logic               out_ready;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic [PIX_W-1:0]   out_red;
	logic [PIX_W-1:0]   out_green;
	logic [PIX_W-1:0]   out_blue;
	logic               run_last;
	logic               frame_done;

	box_mean_board board;
	bit            tx_burst;
	bit            rx_burst;

	box_mean_filter_3x3_top #(
		.MAX_SIDE(SIDE_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.run_last  (run_last),
		.frame_done(frame_done)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Channel value, biased toward the extremes
	function automatic logic [PIX_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic pix_t random_pixel();
		pix_t p;
		p.red   = pick_channel();
		p.green = pick_channel();
		p.blue  = pick_channel();
		return p;
	endfunction

	function automatic pix_t make_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b);
		pix_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		return p;
	endfunction

	// Sends one pixel request; entered and left at a falling edge
	task automatic send_pixel(input pix_t px);
		int gap;
		if ($urandom_range(0, 29) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_red   <= px.red;
		in_green <= px.green;
		in_blue  <= px.blue;
		do @(posedge clk); while (!in_ready);
		board.note_pixel(px);
		@(negedge clk);
	endtask

	// Stop sending until every pending result is back and the pipeline is empty
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Image size write, only with the filter idle
	task automatic write_size(input logic [CFG_W-1:0] v);
		hold_until_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_size(v);
	endtask

	task automatic send_random(input int count, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				hold_until_drained();
			send_pixel(random_pixel());
		end
	endtask

	// Result side: random stalls, check each accepted result
	initial begin
		smooth_pix_t got;
		int          stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 4);
			repeat (stall) begin
				out_ready <= 1'b0;
				@(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.row        = out_row;
			got.col        = out_col;
			got.red        = out_red;
			got.green      = out_green;
			got.blue       = out_blue;
			got.run_last   = run_last;
			got.frame_done = frame_done;
			board.check_result(got);
			@(negedge clk);
		end
	end

	// Watchdog: ends the run after a long stretch with no pixel or result accepted
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: timeout, no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus
	initial begin
		int          sent;
		int          count;
		int          pause_at;
		int unsigned area;
		logic [CFG_W-1:0] size_code;
		board     = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_red    = '0;
		in_green  = '0;
		in_blue   = '0;
		tx_burst  = 1'b0;
		rx_burst  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Size zero acts as one: each pixel passes through unchanged
		write_size('0);
		send_pixel(make_pixel('0, '0, '0));
		send_pixel(make_pixel('1, '1, '1));
		send_pixel(make_pixel(16'h1234, 16'hABCD, 16'h8000));

		// 2x2: every output is a corner window, sums at full scale
		write_size(CFG_W'(2));
		send_pixel(make_pixel('1, '0, '1));
		send_pixel(make_pixel('1, '0, 16'd1));
		send_pixel(make_pixel('1, '0, 16'd2));
		send_pixel(make_pixel('1, '1, 16'd3));

		// 3x3: corners, edges and center; sender holds mid-frame until drained
		write_size(CFG_W'(3));
		for (int i = 0; i < 9; i++) begin
			if (i == 5)
				hold_until_drained();
			send_pixel(make_pixel('1, (i % 2 == 0) ? '1 : '0, PIX_W'($urandom)));
		end

		// Oversized write saturates to the largest side; start a frame there
		write_size('1);
		send_random(4, -1);

		// Random frames: mostly whole frames of small sizes, some cut short
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       size_code = '0;
				1:       size_code = CFG_W'($urandom_range(SIDE_MAX + 1, 1023));
				2:       size_code = CFG_W'($urandom_range(7, 9));
				default: size_code = CFG_W'($urandom_range(1, 6));
			endcase
			write_size(size_code);
			area = board.side * board.side;
			if (board.side > 16)
				count = $urandom_range(1, 8);
			else if ($urandom_range(0, 3) == 0)
				count = $urandom_range(1, area);
			else
				count = area * $urandom_range(1, 2);
			if (count > RANDOM_ITEMS - sent)
				count = RANDOM_ITEMS - sent;
			pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, count - 1) : -1;
			send_random(count, pause_at);
			sent += count;
		end

		// Drain and let the pipeline settle
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### box_mean_filter_3x3_top.f
src/bmf_pkg.sv
src/bmf_line_mem.sv
src/bmf_window.sv
src/bmf_mean.sv
src/box_mean_filter_3x3_top.sv
test/tb_top.sv
